@@ rtl/core/box_blur_3x3_rgb_unit_defines.svh @@
// Assertion macros used by the box blur top level.
`ifndef BOX_BLUR_3X3_RGB_UNIT_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define BB3_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box blur check failed");
// Consequent must hold in the cycle after the antecedent.
`define BB3_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box blur check failed");
`else
`define BB3_ASSERT_SAME(lbl, ante, cons)
`define BB3_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/bb3_pkg.sv @@
// Types and constants shared by the box blur RTL.
`default_nettype none

package bb3_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // Which neighbours of the output pixel lie inside the image.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } nbr_t;

    localparam int unsigned WIDTH_REG_W  = 11;
    localparam int unsigned HEIGHT_REG_W = 16;
    localparam int unsigned CFG_INDEX_W  = 2;
    localparam int unsigned CFG_DATA_W   = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [WIDTH_REG_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

    localparam logic CMD_DRAIN = 1'b1;

    // Nine 8-bit values plus the rounding term fit in 12 bits.
    localparam int unsigned SUM_W       = 12;
    localparam int unsigned RECIP_W     = 21;
    localparam int unsigned RECIP_SHIFT = 20;

    localparam logic [1:0] DIV_ONE   = 2'd0;
    localparam logic [1:0] DIV_THREE = 2'd1;
    localparam logic [1:0] DIV_NINE  = 2'd2;

    // Reciprocals scaled by 2^20, rounded up, exact for 12-bit dividends.
    localparam logic [RECIP_W-1:0] RECIP_ONE   = 21'd1048576;
    localparam logic [RECIP_W-1:0] RECIP_THREE = 21'd349526;
    localparam logic [RECIP_W-1:0] RECIP_NINE  = 21'd116509;

endpackage

`default_nettype wire

@@ rtl/core/bb3_channels.sv @@
// Valid/ready channel interfaces of the box blur: pixels, results and configuration.
`default_nettype none

interface bb3_pixel_if ();
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, output command, output red_in, output green_in,
                    output blue_in, input ready);
    modport sink   (input valid, input command, input red_in, input green_in,
                    input blue_in, output ready);
endinterface

interface bb3_blur_if ();
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output frame_end, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input frame_end, output ready);
endinterface

interface bb3_cfg_if import bb3_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/box_blur_3x3_rgb_unit.sv @@
// Top level of the 3x3 RGB box blur with line stores and a sliding window.
`default_nettype none
`include "box_blur_3x3_rgb_unit_defines.svh"

// The block takes one RGB word per clock in raster order and returns each pixel
// as the rounded-half-up mean of its 3x3 neighbourhood, counting only the
// neighbours that lie inside the frame (nine inside, six on an edge, four in a
// corner). A new word is accepted on every clock edge as long as the output
// side keeps taking results; a result that waits in the output register does
// not stop the pipeline behind it until every stage is full. The result for a
// pixel appears once the word one row plus one pixel later has arrived and has
// passed the line store read, window shift, sum and divide registers, so the
// loop that sets the rate is the line store read and write at the column
// address. After the last pixel of a frame the source sends frame_width+1 drain
// words (command 1) to push out the remaining results; the last result carries
// frame_end, and the word that produces it returns all position counters to
// zero. A drain word that arrives while pixels of the frame are still expected
// is accepted and dropped, and a pixel word after the frame counts as a drain
// word. The two line stores need no clearing pass after reset: entries that
// were never written only reach neighbours outside the frame, which are masked.
// The frame size registers (index 0 width, index 1 height) must be written by
// the user only while the block is idle; the block does not enforce this. Zero
// acts as one and a width above MAX_WIDTH acts as MAX_WIDTH.
module box_blur_3x3_rgb_unit import bb3_pkg::*; #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    bb3_pixel_if.sink     pixel,
    bb3_blur_if.source    blurred,
    bb3_cfg_if.sink       cfg
);

    localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
    localparam int unsigned WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CMP_W  = (WID_W > WIDTH_REG_W) ? WID_W : WIDTH_REG_W;
    localparam int unsigned IROW_W = HEIGHT_REG_W + 1;

    // Configuration.
    logic [WIDTH_REG_W-1:0]  frame_width_reg;
    logic [HEIGHT_REG_W-1:0] frame_height_reg;
    logic                    cfg_write;

    // Effective frame geometry.
    logic [CMP_W-1:0]        fw_ext;
    logic [WID_W-1:0]        w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;

    // Position counters.
    logic [COL_W-1:0]        in_col_reg;
    logic [COL_W-1:0]        in_col_next;
    logic [IROW_W-1:0]       in_row_reg;
    logic [IROW_W-1:0]       in_row_next;
    logic [COL_W-1:0]        out_col_reg;
    logic [COL_W-1:0]        out_col_next;
    logic [HEIGHT_REG_W-1:0] out_row_reg;
    logic [HEIGHT_REG_W-1:0] out_row_next;

    // Decode of the word at the input.
    logic                    accept;
    logic                    clr;
    logic [COL_W-1:0]        icol;
    logic [IROW_W-1:0]       irow;
    logic [COL_W-1:0]        ocol;
    logic [HEIGHT_REG_W-1:0] orow;
    logic                    real_px;
    logic                    ignore;
    logic                    warm;
    logic                    last;
    logic                    load1;
    pixel_t                  px;
    nbr_t                    nbr;

    // Pipeline.
    logic                    s1_valid_reg;
    logic                    s1_emit_reg;
    logic                    s1_last_reg;
    logic                    s1_parity_reg;
    pixel_t                  s1_px_reg;
    nbr_t                    s1_nbr_reg;
    logic                    s2_valid_reg;
    logic                    s2_last_reg;
    nbr_t                    s2_nbr_reg;
    logic                    s3_valid_reg;
    logic                    s3_last_reg;
    logic                    out_valid_reg;
    logic                    out_last_reg;
    logic                    s1_ready;
    logic                    s2_ready;
    logic                    s3_ready;
    logic                    out_free;
    logic                    mv1;
    logic                    mv2;
    logic                    mv3;

    pixel_t                  rd_even;
    pixel_t                  rd_odd;
    pixel_t                  up;
    pixel_t                  mid;
    pixel_t [2:0][2:0]       win_reg;
    pixel_t                  mean;

    // ------------------------------------------------------------------
    // Configuration registers. Writes to an index beyond the list are
    // acknowledged and dropped.
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg.index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data[WIDTH_REG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.data[HEIGHT_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        fw_ext = CMP_W'(frame_width_reg);
        if (frame_width_reg == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (fw_ext > CMP_W'(MAX_WIDTH))
        begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WID_W'(fw_ext);
        end
        h_eff = (frame_height_reg == '0) ? HEIGHT_REG_W'(1) : frame_height_reg;
    end

    // ------------------------------------------------------------------
    // Input decode and position tracking. Counters that fall outside the
    // current frame bounds restart the frame before the word is handled.
    // ------------------------------------------------------------------
    assign pixel.ready = s1_ready;
    assign accept      = pixel.valid && pixel.ready;

    always_comb
    begin
        clr = (WID_W'(in_col_reg) >= w_eff) || (WID_W'(out_col_reg) >= w_eff)
              || (in_row_reg > IROW_W'(h_eff) + IROW_W'(1)) || (out_row_reg >= h_eff);
        icol = clr ? '0 : in_col_reg;
        irow = clr ? '0 : in_row_reg;
        ocol = clr ? '0 : out_col_reg;
        orow = clr ? '0 : out_row_reg;

        // Rows at or beyond the frame height are the drain rows.
        real_px  = irow < IROW_W'(h_eff);
        ignore   = (pixel.command == CMD_DRAIN) && real_px;
        px.red   = real_px ? pixel.red_in   : 8'd0;
        px.green = real_px ? pixel.green_in : 8'd0;
        px.blue  = real_px ? pixel.blue_in  : 8'd0;

        warm = (irow >= IROW_W'(2)) || ((irow == IROW_W'(1)) && (icol != '0));
        last = (orow == h_eff - HEIGHT_REG_W'(1))
               && (WID_W'(ocol) == w_eff - WID_W'(1));

        // At the first column of a row the result is the last pixel of an
        // earlier row, so its right-hand neighbour is never part of the sum.
        nbr.top    = orow != '0;
        nbr.bottom = (IROW_W'(orow) + IROW_W'(1)) < IROW_W'(h_eff);
        nbr.left   = ocol != '0;
        nbr.right  = ((WID_W'(ocol) + WID_W'(1)) < w_eff) && (icol != '0);

        load1 = accept && !ignore;
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (accept)
        begin
            in_col_next  = icol;
            in_row_next  = irow;
            out_col_next = ocol;
            out_row_next = orow;
            if (!ignore)
            begin
                if ((WID_W'(icol) + WID_W'(1)) >= w_eff)
                begin
                    in_col_next = '0;
                    in_row_next = irow + IROW_W'(1);
                end
                else
                begin
                    in_col_next = icol + COL_W'(1);
                end

                if (warm)
                begin
                    if (last)
                    begin
                        in_col_next  = '0;
                        in_row_next  = '0;
                        out_col_next = '0;
                        out_row_next = '0;
                    end
                    else if ((WID_W'(ocol) + WID_W'(1)) >= w_eff)
                    begin
                        out_col_next = '0;
                        out_row_next = orow + HEIGHT_REG_W'(1);
                    end
                    else
                    begin
                        out_col_next = ocol + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line stores. The two stores swap roles each row: the store picked by
    // the row's parity holds the row two above and takes the new pixel, the
    // other holds the row directly above.
    // ------------------------------------------------------------------
    bb3_line_store #(
        .DEPTH   (MAX_WIDTH)
    ) u_store_even (
        .clk     (clk),
        .wr_en   (load1 && !irow[0]),
        .rd_en   (load1),
        .addr    (icol),
        .wr_data (px),
        .rd_data (rd_even)
    );

    bb3_line_store #(
        .DEPTH   (MAX_WIDTH)
    ) u_store_odd (
        .clk     (clk),
        .wr_en   (load1 && irow[0]),
        .rd_en   (load1),
        .addr    (icol),
        .wr_data (px),
        .rd_data (rd_odd)
    );

    assign up  = s1_parity_reg ? rd_odd  : rd_even;
    assign mid = s1_parity_reg ? rd_even : rd_odd;

    // ------------------------------------------------------------------
    // Pipeline handshake. Each stage moves on when the one after it is
    // empty or moving; only words that produce a result go past the window.
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || blurred.ready;
    assign s3_ready = !s3_valid_reg || out_free;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign mv1      = s1_valid_reg && s2_ready;
    assign mv2      = s2_valid_reg && s3_ready;
    assign mv3      = s3_valid_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load1)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (mv1)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (mv1)
            begin
                s2_valid_reg <= s1_emit_reg;
            end
            else if (mv2)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (mv2)
            begin
                s3_valid_reg <= 1'b1;
            end
            else if (mv3)
            begin
                s3_valid_reg <= 1'b0;
            end

            if (mv3)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (blurred.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payloads and the window; the window shifts once per word that
    // reaches it, so the word in the sum stage always sees its own window.
    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            s1_px_reg     <= px;
            s1_parity_reg <= irow[0];
            s1_emit_reg   <= warm;
            s1_last_reg   <= last;
            s1_nbr_reg    <= nbr;
        end
        if (mv1)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= up;
            win_reg[1][2] <= mid;
            win_reg[2][2] <= s1_px_reg;
            s2_last_reg   <= s1_last_reg;
            s2_nbr_reg    <= s1_nbr_reg;
        end
        if (mv2)
        begin
            s3_last_reg <= s2_last_reg;
        end
        if (mv3)
        begin
            out_last_reg <= s3_last_reg;
        end
    end

    bb3_average u_average (
        .clk      (clk),
        .load_sum (mv2),
        .load_out (mv3),
        .win      (win_reg),
        .nbr      (s2_nbr_reg),
        .mean     (mean)
    );

    assign blurred.valid     = out_valid_reg;
    assign blurred.red_out   = mean.red;
    assign blurred.green_out = mean.green;
    assign blurred.blue_out  = mean.blue;
    assign blurred.frame_end = out_last_reg;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `BB3_ASSERT_NEXT(a_drain_dropped, accept && ignore, !s1_valid_reg)
    `BB3_ASSERT_NEXT(a_frame_end_clears, load1 && warm && last, in_col_reg == '0 && in_row_reg == '0 && out_col_reg == '0 && out_row_reg == '0)
    `BB3_ASSERT_NEXT(a_window_holds, s1_valid_reg && !s2_ready, $stable(win_reg))
    `BB3_ASSERT_NEXT(a_no_result_from_silent_word, mv1 && !s1_emit_reg, !s2_valid_reg)

endmodule

`default_nettype wire

@@ rtl/core/bb3_line_store.sv @@
// Line store: one row of pixels, single address, registered read.
`default_nettype none

module bb3_line_store import bb3_pkg::*; #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  pixel_t                   wr_data,
    output pixel_t                   rd_data
);

    pixel_t mem [DEPTH];
    pixel_t rd_data_reg;

    // A read and a write at the same address return the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/bb3_average.sv @@
// Masked 3x3 sum and rounded division by the neighbour count, two register stages.
`default_nettype none

module bb3_average import bb3_pkg::*; (
    input  logic                 clk,
    input  logic                 load_sum,
    input  logic                 load_out,
    input  pixel_t [2:0][2:0]    win,
    input  nbr_t                 nbr,
    output pixel_t               mean
);

    localparam int unsigned PROD_W = SUM_W + RECIP_W;

    logic [2:0]         row_ok;
    logic [2:0]         col_ok;
    logic [SUM_W-1:0]   sum_r;
    logic [SUM_W-1:0]   sum_g;
    logic [SUM_W-1:0]   sum_b;
    logic [1:0]         rows_n;
    logic [1:0]         cols_n;
    logic [3:0]         count;
    logic [2:0]         half;
    logic [1:0]         sh;
    logic [1:0]         div_next;
    logic [SUM_W-1:0]   x_r_next;
    logic [SUM_W-1:0]   x_g_next;
    logic [SUM_W-1:0]   x_b_next;

    logic [SUM_W-1:0]   x_r_reg;
    logic [SUM_W-1:0]   x_g_reg;
    logic [SUM_W-1:0]   x_b_reg;
    logic [1:0]         div_reg;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod_r;
    logic [PROD_W-1:0]  prod_g;
    logic [PROD_W-1:0]  prod_b;
    pixel_t             mean_reg;

    always_comb
    begin
        row_ok = {nbr.bottom, 1'b1, nbr.top};
        col_ok = {nbr.right, 1'b1, nbr.left};
        sum_r  = '0;
        sum_g  = '0;
        sum_b  = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (row_ok[r] && col_ok[c])
                begin
                    sum_r = sum_r + SUM_W'(win[r][c].red);
                    sum_g = sum_g + SUM_W'(win[r][c].green);
                    sum_b = sum_b + SUM_W'(win[r][c].blue);
                end
            end
        end

        rows_n = 2'd1 + 2'(nbr.top) + 2'(nbr.bottom);
        cols_n = 2'd1 + 2'(nbr.left) + 2'(nbr.right);
        count  = 4'(rows_n) * 4'(cols_n);

        // Rounding half up is floor((sum + floor(n/2)) / n); even counts lose
        // their factors of two to a shift first.
        case (count)
            4'd2:
            begin
                half = 3'd1; sh = 2'd1; div_next = DIV_ONE;
            end
            4'd3:
            begin
                half = 3'd1; sh = 2'd0; div_next = DIV_THREE;
            end
            4'd4:
            begin
                half = 3'd2; sh = 2'd2; div_next = DIV_ONE;
            end
            4'd6:
            begin
                half = 3'd3; sh = 2'd1; div_next = DIV_THREE;
            end
            4'd9:
            begin
                half = 3'd4; sh = 2'd0; div_next = DIV_NINE;
            end
            default:
            begin
                half = 3'd0; sh = 2'd0; div_next = DIV_ONE;
            end
        endcase

        x_r_next = (sum_r + SUM_W'(half)) >> sh;
        x_g_next = (sum_g + SUM_W'(half)) >> sh;
        x_b_next = (sum_b + SUM_W'(half)) >> sh;
    end

    always_ff @(posedge clk)
    begin
        if (load_sum)
        begin
            x_r_reg <= x_r_next;
            x_g_reg <= x_g_next;
            x_b_reg <= x_b_next;
            div_reg <= div_next;
        end
    end

    always_comb
    begin
        case (div_reg)
            DIV_THREE: recip = RECIP_THREE;
            DIV_NINE:  recip = RECIP_NINE;
            default:   recip = RECIP_ONE;
        endcase
        prod_r = PROD_W'(x_r_reg) * PROD_W'(recip);
        prod_g = PROD_W'(x_g_reg) * PROD_W'(recip);
        prod_b = PROD_W'(x_b_reg) * PROD_W'(recip);
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            mean_reg.red   <= prod_r[RECIP_SHIFT +: 8];
            mean_reg.green <= prod_g[RECIP_SHIFT +: 8];
            mean_reg.blue  <= prod_b[RECIP_SHIFT +: 8];
        end
    end

    assign mean = mean_reg;

endmodule

`default_nettype wire
